// ===== rtl/odi_pkg.sv =====
// ----------------------------------------------------------------------------
// odi_pkg
// Shared types, constants and lookup functions for the ordered-dither
// RGB to colormap index pipeline.
// ----------------------------------------------------------------------------
package odi_pkg;

    localparam logic [2:0] LEVELS_MIN   = 3'd2;
    localparam logic [2:0] LEVELS_MAX   = 3'd6;
    localparam logic [2:0] LEVELS_RESET = 3'd2;
    localparam logic [7:0] FULL_SCALE   = 8'd255;

    // Load enables for the three inner pipeline stages
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } pipe_ctl_t;

    // 4x4 magic square, first index is the column coordinate
    function automatic logic [3:0] magic_entry(input logic [1:0] col, input logic [1:0] row);
        logic [3:0] e;
        e = 4'd0;
        unique case ({col, row})
            4'b0000: e = 4'd0;
            4'b0001: e = 4'd14;
            4'b0010: e = 4'd3;
            4'b0011: e = 4'd13;
            4'b0100: e = 4'd11;
            4'b0101: e = 4'd5;
            4'b0110: e = 4'd8;
            4'b0111: e = 4'd6;
            4'b1000: e = 4'd12;
            4'b1001: e = 4'd2;
            4'b1010: e = 4'd15;
            4'b1011: e = 4'd1;
            4'b1100: e = 4'd7;
            4'b1101: e = 4'd9;
            4'b1110: e = 4'd4;
            4'b1111: e = 4'd10;
        endcase
        return e;
    endfunction

    // Clamp the programmed level count into the supported range
    function automatic logic [2:0] clamp_levels(input logic [2:0] lv);
        logic [2:0] r;
        r = lv;
        if (lv < LEVELS_MIN) begin
            r = LEVELS_MIN;
        end else if (lv > LEVELS_MAX) begin
            r = LEVELS_MAX;
        end
        return r;
    endfunction

    // Divide an 8-bit value by a step count of 1..5 (reciprocal multiply)
    function automatic logic [7:0] div_steps(input logic [7:0] t, input logic [2:0] steps);
        logic [17:0] prod3;
        logic [17:0] prod5;
        logic [7:0]  q;
        prod3 = {10'd0, t} * 18'd171;
        prod5 = {10'd0, t} * 18'd205;
        q     = t;
        unique case (steps)
            3'd2:    q = {1'b0, t[7:1]};
            3'd3:    q = prod3[16:9];
            3'd4:    q = {2'b00, t[7:2]};
            3'd5:    q = prod5[17:10];
            default: q = t;
        endcase
        return q;
    endfunction

    // Lower edge of level q: floor(q*255/steps)
    function automatic logic [7:0] base_value(input logic [2:0] steps, input logic [2:0] q);
        logic [7:0] b;
        b = 8'd0;
        unique case (steps)
            3'd2: begin
                unique case (q)
                    3'd1:    b = 8'd127;
                    3'd2:    b = 8'd255;
                    default: b = 8'd0;
                endcase
            end
            3'd3: begin
                unique case (q)
                    3'd1:    b = 8'd85;
                    3'd2:    b = 8'd170;
                    3'd3:    b = 8'd255;
                    default: b = 8'd0;
                endcase
            end
            3'd4: begin
                unique case (q)
                    3'd1:    b = 8'd63;
                    3'd2:    b = 8'd127;
                    3'd3:    b = 8'd191;
                    3'd4:    b = 8'd255;
                    default: b = 8'd0;
                endcase
            end
            3'd5: begin
                unique case (q)
                    3'd1:    b = 8'd51;
                    3'd2:    b = 8'd102;
                    3'd3:    b = 8'd153;
                    3'd4:    b = 8'd204;
                    3'd5:    b = 8'd255;
                    default: b = 8'd0;
                endcase
            end
            default: begin
                b = (q == 3'd1) ? 8'd255 : 8'd0;
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/ordered_dither_rgb_to_index_top.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_rgb_to_index_top
// Ordered 16x16 dither of RGB pixels to a colormap index.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one pixel per request: three 8-bit samples
//   and the pixel position modulo 16. Output stream m_axis carries the
//   colormap index dr + dg*L + db*L*L for each pixel, in order.
//   cfg_we/cfg_wdata set the level count L (2..6, values outside clamp);
//   write it only while the pipeline is empty.
// Timing:
//   Four register stages (pattern/base level, numerator/remainder,
//   threshold divide and level decision, index combine), A to D in order; a
//   pixel passes all four and leaves on m_axis from stage D. One pixel per
//   cycle is sustained while m_axis_tready is high (per-stage valid chain).
// Reset:
//   aresetn low empties all stages and sets L to 2.
// Stall:
//   When m_axis_tready is low the output holds; stages fill behind it and
//   s_axis_tready drops only once every stage holds a pixel.
// ----------------------------------------------------------------------------
module ordered_dither_rgb_to_index_top import odi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    // Pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                        // column[27:24], line[31:28]
    // Index output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // color_index[7:0]
);

    logic [2:0] levels_reg;
    logic       valid_a_reg;
    logic       valid_b_reg;
    logic       valid_c_reg;
    logic       valid_d_reg;
    logic [2:0] lv_a_reg;
    logic [5:0] lvsq_a_reg;
    logic [2:0] lv_b_reg;
    logic [5:0] lvsq_b_reg;
    logic [2:0] lv_c_reg;
    logic [5:0] lvsq_c_reg;
    logic [7:0] index_reg;

    logic       ready_a;
    logic       ready_b;
    logic       ready_c;
    logic       ready_d;
    pipe_ctl_t  ctl;
    logic [2:0] lv_eff;
    logic [2:0] steps;
    logic [7:0] thresh;
    logic [2:0] level_r;
    logic [2:0] level_g;
    logic [2:0] level_b;
    logic [5:0] green_term;
    logic [8:0] blue_term;
    logic [8:0] index_sum;

    // Hold the level count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
        end else if (cfg_we) begin
            levels_reg <= cfg_wdata;
        end
    end

    assign lv_eff = clamp_levels(levels_reg);
    assign steps  = lv_eff - 3'd1;

    // Advance a stage when it is empty or its successor advances
    assign ready_d = !valid_d_reg || m_axis_tready;
    assign ready_c = !valid_c_reg || ready_d;
    assign ready_b = !valid_b_reg || ready_c;
    assign ready_a = !valid_a_reg || ready_b;

    assign ctl.load_a = ready_a;
    assign ctl.load_b = ready_b;
    assign ctl.load_c = ready_c;

    assign s_axis_tready = ready_a;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (ready_a) valid_a_reg <= s_axis_tvalid;
            if (ready_b) valid_b_reg <= valid_a_reg;
            if (ready_c) valid_c_reg <= valid_b_reg;
            if (ready_d) valid_d_reg <= valid_c_reg;
        end
    end

    // Carry L and L*L alongside the pixel
    always_ff @(posedge aclk) begin
        if (ready_a) begin
            lv_a_reg   <= lv_eff;
            lvsq_a_reg <= {3'd0, lv_eff} * {3'd0, lv_eff};
        end
        if (ready_b) begin
            lv_b_reg   <= lv_a_reg;
            lvsq_b_reg <= lvsq_a_reg;
        end
        if (ready_c) begin
            lv_c_reg   <= lv_b_reg;
            lvsq_c_reg <= lvsq_b_reg;
        end
    end

    odi_thresh u_thresh (
        .aclk     (aclk),
        .ctl      (ctl),
        .column   (s_axis_tdata[27:24]),
        .pix_line (s_axis_tdata[31:28]),
        .levels   (lv_eff),
        .steps    (steps),
        .thresh   (thresh)
    );

    odi_chan u_chan_r (
        .aclk   (aclk),
        .ctl    (ctl),
        .sample (s_axis_tdata[7:0]),
        .steps  (steps),
        .thresh (thresh),
        .level  (level_r)
    );

    odi_chan u_chan_g (
        .aclk   (aclk),
        .ctl    (ctl),
        .sample (s_axis_tdata[15:8]),
        .steps  (steps),
        .thresh (thresh),
        .level  (level_g)
    );

    odi_chan u_chan_b (
        .aclk   (aclk),
        .ctl    (ctl),
        .sample (s_axis_tdata[23:16]),
        .steps  (steps),
        .thresh (thresh),
        .level  (level_b)
    );

    // Combine channel levels into the colormap index
    assign green_term = {3'd0, level_g} * {3'd0, lv_c_reg};
    assign blue_term  = {6'd0, level_b} * {3'd0, lvsq_c_reg};
    assign index_sum  = {6'd0, level_r} + {3'd0, green_term} + blue_term;

    // Stage D: output register
    always_ff @(posedge aclk) begin
        if (ready_d) begin
            index_reg <= index_sum[7:0];
        end
    end

    assign m_axis_tvalid = valid_d_reg;
    assign m_axis_tdata  = index_reg;

endmodule

// ===== rtl/odi_thresh.sv =====
// ----------------------------------------------------------------------------
// odi_thresh
// Dither threshold path: magic square lookup, scaled threshold numerator,
// then division by the step count. Threshold is valid at stage C.
// ----------------------------------------------------------------------------
module odi_thresh import odi_pkg::*; (
    input  logic       aclk,
    input  pipe_ctl_t  ctl,
    input  logic [3:0] column,
    input  logic [3:0] pix_line,
    input  logic [2:0] levels,
    input  logic [2:0] steps,
    output logic [7:0] thresh
);

    logic [7:0]  cell_a_reg;
    logic [2:0]  lv_a_reg;
    logic [2:0]  steps_a_reg;
    logic [7:0]  scaled_b_reg;
    logic [2:0]  steps_b_reg;

    logic [7:0]  cell_next;
    logic [8:0]  span;
    logic [16:0] prod;
    logic [16:0] num;

    // Combine fine and coarse pattern entries into 16*A+B
    assign cell_next = {magic_entry(column[1:0], pix_line[1:0]),
                        magic_entry(column[3:2], pix_line[3:2])};

    // Stage A: hold pattern value and level count
    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            cell_a_reg  <= cell_next;
            lv_a_reg    <= levels;
            steps_a_reg <= steps;
        end
    end

    // Numerator 256*steps + 2*(256-L)*n, then drop the factor 512
    assign span = 9'd256 - {6'd0, lv_a_reg};
    assign prod = {8'd0, span} * {9'd0, cell_a_reg};
    assign num  = {6'd0, steps_a_reg, 8'd0} + {prod[15:0], 1'b0};

    // Stage B: hold the pre-divided threshold
    always_ff @(posedge aclk) begin
        if (ctl.load_b) begin
            scaled_b_reg <= num[16:9];
            steps_b_reg  <= steps_a_reg;
        end
    end

    assign thresh = div_steps(scaled_b_reg, steps_b_reg);

endmodule

// ===== rtl/odi_chan.sv =====
// ----------------------------------------------------------------------------
// odi_chan
// One color channel: base level, remainder above the level edge, and the
// dithered level decision against the threshold.
// ----------------------------------------------------------------------------
module odi_chan import odi_pkg::*; (
    input  logic       aclk,
    input  pipe_ctl_t  ctl,
    input  logic [7:0] sample,
    input  logic [2:0] steps,
    input  logic [7:0] thresh,
    output logic [2:0] level
);

    logic [7:0]  sample_a_reg;
    logic [2:0]  q_a_reg;
    logic [2:0]  steps_a_reg;
    logic [7:0]  rem_b_reg;
    logic [2:0]  q_b_reg;
    logic [2:0]  level_c_reg;

    logic [10:0] scaled;
    logic [10:0] quot_sum;
    logic [7:0]  edge_val;
    logic [7:0]  rem_next;

    // Base level floor(v*steps/255) by the divide-by-255 identity
    assign scaled   = {3'd0, sample} * {8'd0, steps};
    assign quot_sum = scaled + {8'd0, scaled[10:8]} + 11'd1;

    // Stage A: hold sample and base level
    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            sample_a_reg <= sample;
            q_a_reg      <= quot_sum[10:8];
            steps_a_reg  <= steps;
        end
    end

    // Remainder above the level edge, zero at full scale
    assign edge_val = base_value(steps_a_reg, q_a_reg);
    assign rem_next = (sample_a_reg == FULL_SCALE) ? 8'd0 : (sample_a_reg - edge_val);

    // Stage B: hold remainder
    always_ff @(posedge aclk) begin
        if (ctl.load_b) begin
            rem_b_reg <= rem_next;
            q_b_reg   <= q_a_reg;
        end
    end

    // Stage C: step up one level when the remainder beats the threshold
    always_ff @(posedge aclk) begin
        if (ctl.load_c) begin
            level_c_reg <= (rem_b_reg > thresh) ? (q_b_reg + 3'd1) : q_b_reg;
        end
    end

    assign level = level_c_reg;

endmodule

// ===== rtl/odi_checker.sv =====
// ----------------------------------------------------------------------------
// odi_checker
// Port-level checks for the dither pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module odi_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // Stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped during stall");

    // Stalled result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("m_axis_tdata changed during stall");

    // Index stays inside the largest colormap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata <= 8'd215)
        else $error("color index out of range");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind ordered_dither_rgb_to_index_top odi_checker u_odi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_ordered_dither_rgb_to_index_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_rgb_to_index_top
// Self-checking bench for the ordered-dither RGB to colormap index pipeline.
// Pixels go in on s_axis. A local model of the 16x16 magic-square dither
// predicts each color index, and every index that leaves on m_axis is
// compared with it in order. The level count is swept through every
// register value, including the clamped ones. Both streams idle at random,
// and the output side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_ordered_dither_rgb_to_index_top import odi_pkg::*; ;

    localparam int unsigned IDLE_PERCENT     = 27;
    localparam int unsigned HOLD_OFF_CYCLES  = 60;
    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned PIXELS_PER_PHASE = 85;
    localparam int unsigned PHASE_COUNT      = 8;

    // 4x4 magic square, first index is the column coordinate
    localparam int unsigned DITHER_SQUARE [4][4] = '{
        '{ 0, 14,  3, 13},
        '{11,  5,  8,  6},
        '{12,  2, 15,  1},
        '{ 7,  9,  4, 10}
    };

    // Level counts for the random phases, clamped values included
    localparam logic [2:0] LEVEL_SWEEP [PHASE_COUNT] = '{
        3'd6, 3'd3, 3'd0, 3'd4, 3'd7, 3'd5, 3'd1, 3'd2
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] column;
        logic [3:0] line;
    } pixel_t;

    // Predicted color indices in request order, plus the level register copy
    class index_ledger;
        logic [2:0]  levels_reg;
        logic [7:0]  pending [$];
        int unsigned failures;
        int unsigned checked;

        function new();
            levels_reg = LEVELS_RESET;
            failures   = 0;
            checked    = 0;
        endfunction

        function void set_levels(logic [2:0] value);
            levels_reg = value;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        // Quantize each channel against the position threshold and combine
        function logic [7:0] dithered_index(pixel_t px);
            int unsigned lv;
            int unsigned steps;
            int unsigned a;
            int unsigned b;
            int unsigned thr;
            int unsigned v;
            int unsigned q;
            int unsigned rem;
            int unsigned idx;
            int unsigned lvl [3];
            logic [7:0]  smp [3];
            lv = levels_reg;
            if (lv < 2) lv = 2;
            if (lv > 6) lv = 6;
            steps = lv - 1;
            a   = DITHER_SQUARE[px.column[1:0]][px.line[1:0]];
            b   = DITHER_SQUARE[px.column[3:2]][px.line[3:2]];
            thr = (256 * steps + 2 * (256 - lv) * (16 * a + b)) / (512 * steps);
            smp = '{px.red, px.green, px.blue};
            for (int i = 0; i < 3; i++) begin
                v   = smp[i];
                q   = (v * steps) / 255;
                rem = v - (q * 255) / steps;
                // full-scale sample never rounds up
                if (v == 255) rem = 0;
                lvl[i] = (rem > thr) ? q + 1 : q;
            end
            idx = lvl[0] + lvl[1] * lv + lvl[2] * lv * lv;
            return idx[7:0];
        endfunction

        function void note_pixel(pixel_t px);
            pending.push_back(dithered_index(px));
        endfunction

        function void check_index(logic [7:0] got);
            logic [7:0] want;
            if (pending.size() == 0) begin
                $error("color_index %0d arrived with no pixel outstanding", got);
                failures++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                $error("color_index mismatch: expected %0d, actual %0d", want, got);
                failures++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red[7:0], green[15:8], blue[23:16],
                                 // column[27:24], line[31:28]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // color_index[7:0]

    bit          steady_run    = 1'b0;
    logic        stall_request = 1'b0;
    int unsigned pixels_sent   = 0;

    index_ledger ledger = new();

    ordered_dither_rgb_to_index_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one pixel, with a random gap unless in a steady run; hold until taken
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [3:0] col,
                              input logic [3:0] ln);
        pixel_t px;
        px = '{red: r, green: g, blue: b, column: col, line: ln};
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.line, px.column, px.blue, px.green, px.red};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ledger.note_pixel(px);
        pixels_sent++;
    endtask

    // Drop valid and wait until every predicted index has come back
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_levels(input logic [2:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        ledger.set_levels(value);
    endtask

    // Uniform samples half the time, otherwise 0, 255 or values around level edges
    function automatic logic [7:0] pick_sample();
        int unsigned s;
        int unsigned e;
        int          v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = 255;
            2, 3: begin
                s = $urandom_range(5, 1);
                e = ($urandom_range(s) * 255) / s;
                v = int'(e) - 1 + int'($urandom_range(2));
            end
            default: v = $urandom_range(255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Output side: random ready, with one long hold-off on request
    initial begin : index_sink
        int unsigned hold_left;
        bit          stall_taken;
        hold_left     = 0;
        stall_taken   = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request && !stall_taken) begin
                hold_left   = HOLD_OFF_CYCLES;
                stall_taken = 1'b1;
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Check every index that leaves the block
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            ledger.check_index(m_axis_tdata);
        end
    end

    // Abort when neither stream moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_ordered_dither_rgb_to_index_top failed");
        $finish;
    end

    initial begin : stimulus
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pixels at the reset level setting: corners, full scale, values around mid-scale
        send_pixel(8'd0,   8'd0,   8'd0,   4'd0,  4'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 4'd15, 4'd15);
        send_pixel(8'd255, 8'd255, 8'd255, 4'd0,  4'd0);
        send_pixel(8'd0,   8'd0,   8'd0,   4'd15, 4'd15);
        send_pixel(8'd127, 8'd127, 8'd127, 4'd0,  4'd0);
        send_pixel(8'd128, 8'd128, 8'd128, 4'd0,  4'd0);
        send_pixel(8'd128, 8'd128, 8'd128, 4'd15, 4'd15);
        send_pixel(8'd126, 8'd127, 8'd128, 4'd5,  4'd10);
        send_pixel(8'd1,   8'd254, 8'd200, 4'd3,  4'd12);
        send_pixel(8'd255, 8'd0,   8'd128, 4'd12, 4'd3);
        send_pixel(8'd64,  8'd192, 8'd32,  4'd7,  4'd9);
        send_pixel(8'd200, 8'd100, 8'd50,  4'd8,  4'd8);
        send_pixel(8'd254, 8'd1,   8'd255, 4'd10, 4'd5);
        send_pixel(8'd85,  8'd170, 8'd43,  4'd1,  4'd14);
        send_pixel(8'd129, 8'd126, 8'd250, 4'd14, 4'd1);
        send_pixel(8'd30,  8'd240, 8'd255, 4'd2,  4'd6);
        send_pixel(8'd255, 8'd128, 8'd0,   4'd6,  4'd2);
        send_pixel(8'd170, 8'd85,  8'd255, 4'd11, 4'd13);
        send_pixel(8'd5,   8'd250, 8'd127, 4'd13, 4'd11);
        send_pixel(8'd120, 8'd130, 8'd140, 4'd4,  4'd15);
        send_pixel(8'd0,   8'd255, 8'd0,   4'd15, 4'd4);

        // Random phases, one per level count; reprogram only when empty
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_pipeline();
            write_levels(LEVEL_SWEEP[p]);
            steady_run = (p == 1);
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                if (p == 3 && n == 10) stall_request <= 1'b1;
                send_pixel(pick_sample(), pick_sample(), pick_sample(),
                           4'($urandom_range(15)), 4'($urandom_range(15)));
            end
        end
        steady_run = 1'b0;

        // Let the pipeline empty, then wait for strays before the final check
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.outstanding() != 0) begin
            $error("%0d color indices never arrived", ledger.outstanding());
            ledger.failures++;
        end

        $display("Covered %0d pixels and checked %0d indices across all eight level",
                 pixels_sent, ledger.checked);
        $display("register values, with random gaps, a steady run and a long output stall.");
        if (ledger.failures == 0) begin
            $display("tb_ordered_dither_rgb_to_index_top passed");
        end else begin
            $display("tb_ordered_dither_rgb_to_index_top failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/odi_pkg.sv
rtl/odi_thresh.sv
rtl/odi_chan.sv
rtl/ordered_dither_rgb_to_index_top.sv
rtl/odi_checker.sv
verif/tb_ordered_dither_rgb_to_index_top.sv
